@@ src/ppsm_pkg.sv @@
package ppsm_pkg;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_WHEEL_CIRC  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PULSES      = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_REFRESH     = 2'd2;

	localparam logic [15:0] RST_WHEEL_CIRC = 16'd2170;
	localparam logic [7:0]  RST_PULSES     = 8'd1;
	localparam logic [15:0] RST_REFRESH    = 16'd500;

	// 3.6 km/h per m/s times 100 for hundredths.
	localparam int NUM_W = 25;
	localparam logic [NUM_W-1:0] SPEED_SCALE = 25'd360;

	localparam int SPEED_W = 16;
	localparam int QUO_CNT_W = 4;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = 1;

	typedef struct packed {
		logic level;
		logic updated;
		logic strobe;
	} ppsm_flags_t;

	localparam int FLAGS_W = $bits(ppsm_flags_t);

endpackage

@@ src/pulse_period_speed_meter.sv @@
// Pulse-period speed meter.
// Push one transaction per millisecond tick with the sampled encoder level on
// sensor_level; each accepted tick yields exactly one result transaction, in
// order, read from the result side while empty is low and taken with pop.
// A result carries the mirrored level, an update flag, the held speed in
// hundredths of km/h and the display refresh strobe.
// A tick without a rising edge passes through S_IDLE and S_OUT in the back end
// into the output register. A rising edge runs the speed calculation: a
// multiply step, a setup step and a restoring divider for the 16-bit quotient;
// the back end takes no new tick from the queue until its result is out.
// A two-entry queue between the edge detector and the divider lets ticks be
// accepted while a division runs; full rises when that queue fills.
// If the receiver stops popping, the output register holds its transaction,
// the back end waits, then the queue fills and full is raised.
// Reset clears counters, the held speed and the queue and loads the defaults:
// 2170 mm circumference, 1 pulse per turn, a refresh period of 500 ticks.
// The user must write configuration only while idle; the block does not check.
module pulse_period_speed_meter #(
	parameter int COUNT_WIDTH = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        sensor_level,
	output logic        empty,
	input  logic        pop,
	output logic        pulse_mirror,
	output logic        speed_updated,
	output logic [15:0] speed_centi_kmh,
	output logic        refresh_strobe,
	input  logic        cfg_we,
	input  logic [ppsm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [ppsm_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import ppsm_pkg::*;

	localparam int QW = FLAGS_W + COUNT_WIDTH;

	logic [15:0]            circ_q;
	logic [7:0]             pulses_q;
	logic [15:0]            refresh_q;

	logic                   enq;
	logic                   deq;
	logic                   q_full;
	logic                   q_empty;
	ppsm_flags_t            enq_flags;
	logic [COUNT_WIDTH-1:0] enq_ticks;
	logic [QW-1:0]          q_rd_data;
	ppsm_flags_t            q_flags;
	logic [COUNT_WIDTH-1:0] q_ticks;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			circ_q    <= RST_WHEEL_CIRC;
			pulses_q  <= RST_PULSES;
			refresh_q <= RST_REFRESH;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WHEEL_CIRC: circ_q    <= cfg_data;
				REG_PULSES:     pulses_q  <= cfg_data[7:0];
				REG_REFRESH:    refresh_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign full = q_full;

	ppsm_front #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.sensor_level   (sensor_level),
		.q_full         (q_full),
		.refresh_period (refresh_q),
		.enq            (enq),
		.flags          (enq_flags),
		.ticks          (enq_ticks)
	);

	ppsm_queue #(
		.W(QW)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (enq),
		.wr_data ({enq_flags, enq_ticks}),
		.rd      (deq),
		.rd_data (q_rd_data),
		.full    (q_full),
		.empty   (q_empty)
	);

	assign q_flags = q_rd_data[QW-1:COUNT_WIDTH];
	assign q_ticks = q_rd_data[COUNT_WIDTH-1:0];

	ppsm_back #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_back (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.q_empty                (q_empty),
		.q_flags                (q_flags),
		.q_ticks                (q_ticks),
		.deq                    (deq),
		.wheel_circumference_mm (circ_q),
		.pulses_per_turn        (pulses_q),
		.pop                    (pop),
		.empty                  (empty),
		.pulse_mirror           (pulse_mirror),
		.speed_updated          (speed_updated),
		.speed_centi_kmh        (speed_centi_kmh),
		.refresh_strobe         (refresh_strobe)
	);

endmodule

@@ src/ppsm_queue.sv @@
module ppsm_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wr_data,
	input  logic         rd,
	output logic [W-1:0] rd_data,
	output logic         full,
	output logic         empty
);
	import ppsm_pkg::*;

	logic [W-1:0]          mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_AW:0]     count_q;

	assign full    = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

@@ src/ppsm_front.sv @@
module ppsm_front #(
	parameter int COUNT_WIDTH = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic                   sensor_level,
	input  logic                   q_full,
	input  logic [15:0]            refresh_period,
	output logic                   enq,
	output ppsm_pkg::ppsm_flags_t  flags,
	output logic [COUNT_WIDTH-1:0] ticks
);
	import ppsm_pkg::*;

	logic                   prev_level_q;
	logic [COUNT_WIDTH-1:0] ticks_q;
	logic [15:0]            refresh_q;
	logic                   edge_det;
	logic                   strobe;
	logic [COUNT_WIDTH-1:0] ticks_base;
	logic [15:0]            refresh_base;

	assign enq      = push && !q_full;
	assign edge_det = sensor_level && !prev_level_q;
	assign strobe   = (refresh_q >= refresh_period);

	assign ticks_base   = edge_det ? '0 : ticks_q;
	assign refresh_base = strobe ? '0 : refresh_q;

	// The back end needs the count as it stood before this tick cleared it.
	assign flags.level   = sensor_level;
	assign flags.updated = edge_det;
	assign flags.strobe  = strobe;
	assign ticks         = ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q <= 1'b0;
			ticks_q      <= '0;
			refresh_q    <= '0;
		end else if (enq) begin
			prev_level_q <= sensor_level;
			ticks_q      <= (ticks_base != '1) ? ticks_base + 1'b1 : ticks_base;
			refresh_q    <= (refresh_base != '1) ? refresh_base + 1'b1 : refresh_base;
		end
	end

endmodule

@@ src/ppsm_back.sv @@
module ppsm_back #(
	parameter int COUNT_WIDTH = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_empty,
	input  ppsm_pkg::ppsm_flags_t  q_flags,
	input  logic [COUNT_WIDTH-1:0] q_ticks,
	output logic                   deq,
	input  logic [15:0]            wheel_circumference_mm,
	input  logic [7:0]             pulses_per_turn,
	input  logic                   pop,
	output logic                   empty,
	output logic                   pulse_mirror,
	output logic                   speed_updated,
	output logic [15:0]            speed_centi_kmh,
	output logic                   refresh_strobe
);
	import ppsm_pkg::*;

	localparam int DEN_W = COUNT_WIDTH + 8;
	localparam int WW    = COUNT_WIDTH + 26;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_PREP,
		S_DIV,
		S_OUT
	} state_t;

	state_t               state_q;
	ppsm_flags_t          flags_q;
	logic [COUNT_WIDTH-1:0] ticks_q;
	logic [NUM_W-1:0]     num_q;
	logic [DEN_W-1:0]     den_q;
	logic [WW-1:0]        rem_q;
	logic [WW-1:0]        div_q;
	logic [SPEED_W-1:0]   quo_q;
	logic [QUO_CNT_W-1:0] cnt_q;
	logic [SPEED_W-1:0]   speed_q;
	logic                 out_valid_q;
	logic                 out_level_q;
	logic                 out_updated_q;
	logic                 out_strobe_q;
	logic [SPEED_W-1:0]   out_speed_q;

	logic [WW-1:0]        dividend;
	logic [WW-1:0]        divisor;
	logic                 rem_ge;
	logic [SPEED_W-1:0]   quo_next;
	logic                 slot_free;

	assign deq       = (state_q == S_IDLE) && !q_empty;
	assign slot_free = !out_valid_q || pop;

	// Rounded quotient: (2*num + den) / (2*den).
	assign dividend = WW'({num_q, 1'b0}) + WW'(den_q);
	assign divisor  = WW'({den_q, 1'b0});
	assign rem_ge   = (rem_q >= div_q);
	assign quo_next = {quo_q[SPEED_W-2:0], rem_ge};

	assign empty           = !out_valid_q;
	assign pulse_mirror    = out_level_q;
	assign speed_updated   = out_updated_q;
	assign speed_centi_kmh = out_speed_q;
	assign refresh_strobe  = out_strobe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			flags_q       <= '0;
			ticks_q       <= '0;
			num_q         <= '0;
			den_q         <= '0;
			rem_q         <= '0;
			div_q         <= '0;
			quo_q         <= '0;
			cnt_q         <= '0;
			speed_q       <= '0;
			out_valid_q   <= 1'b0;
			out_level_q   <= 1'b0;
			out_updated_q <= 1'b0;
			out_strobe_q  <= 1'b0;
			out_speed_q   <= '0;
		end else begin
			if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						flags_q <= q_flags;
						ticks_q <= q_ticks;
						state_q <= q_flags.updated ? S_MUL : S_OUT;
					end
				end
				S_MUL: begin
					num_q   <= NUM_W'(wheel_circumference_mm) * SPEED_SCALE;
					den_q   <= DEN_W'(pulses_per_turn) * DEN_W'(ticks_q);
					state_q <= S_PREP;
				end
				S_PREP: begin
					if (den_q == '0) begin
						speed_q <= '0;
						state_q <= S_OUT;
					end else if (dividend >= (divisor << SPEED_W)) begin
						speed_q <= '1;
						state_q <= S_OUT;
					end else begin
						rem_q   <= dividend;
						div_q   <= divisor << (SPEED_W - 1);
						quo_q   <= '0;
						cnt_q   <= QUO_CNT_W'(SPEED_W - 1);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (rem_ge) begin
						rem_q <= rem_q - div_q;
					end
					div_q <= div_q >> 1;
					quo_q <= quo_next;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						speed_q <= quo_next;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (slot_free) begin
						out_valid_q   <= 1'b1;
						out_level_q   <= flags_q.level;
						out_updated_q <= flags_q.updated;
						out_strobe_q  <= flags_q.strobe;
						out_speed_q   <= speed_q;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
